// ----- src/gea_pkg.sv -----
// Shared types and constants for the greedy edge acceptor.
`default_nettype none

package gea_pkg;

    localparam int CITY_W = 10;
    localparam int CFG_W = 11;
    localparam int RANK_W = 4;
    localparam int DEG_W = 2;
    localparam int COUNT_W = 10;
    localparam int VERDICT_W = 3;
    localparam int MAX_CITIES_DEF = 1024;

    localparam logic [CFG_W-1:0] CITY_COUNT_RST = 11'd1024;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [DEG_W-1:0] DEGREE_FULL = 2'd2;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DEGREE = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SAME = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_QUOTA = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD = 3'd4;

    typedef struct packed {
        logic              mode;
        logic [CITY_W-1:0] first_city;
        logic [CITY_W-1:0] second_city;
    } gea_in_t;

    typedef struct packed {
        logic                 accepted;
        logic [VERDICT_W-1:0] verdict;
        logic                 first_slot;
        logic                 second_slot;
        logic [COUNT_W-1:0]   edges_taken;
    } gea_out_t;

endpackage

`default_nettype wire

// ----- src/gea_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/greedy_edge_acceptor.sv -----
// Top level of the greedy edge acceptor: degree check and union-find over one RAM.
`default_nettype none

// An item is taken when start is high and busy is low, and its one result is shown on
// result for exactly one cycle with done high; the receiver cannot hold it off, so it must
// take it then. A bad pair or a full quota answers in the cycle right after acceptance, a
// full degree once the RD_U, CHK_U and CHK_V states have run. An edge that reaches the
// forest keeps busy high through its two root searches and, when it is accepted, through
// the degree updates and the join of the roots; its result comes in the first cycle with
// busy low. Every path-halving step of a search is a read and a write of the single city
// RAM, which sets its pace. After reset, and for every clear item, a clearing pass writes
// all MAX_CITIES RAM entries, one per cycle, while busy stays high; the result of a clear
// item comes in the cycle after the pass ends. Configuration writes are taken in any cycle.
module greedy_edge_acceptor
    import gea_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire gea_in_t          item,
    output logic                  done,
    output gea_out_t              result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_CITIES);
    localparam int WW = AW + RANK_W + DEG_W;
    localparam int LIM_W = $clog2(MAX_CITIES + 1);
    localparam int NW = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    typedef enum logic [14:0] {
        IDLE      = 15'b000000000000001,
        CLEAR     = 15'b000000000000010,
        RD_U      = 15'b000000000000100,
        CHK_U     = 15'b000000000001000,
        CHK_V     = 15'b000000000010000,
        FIND_X    = 15'b000000000100000,
        FIND_P    = 15'b000000001000000,
        UPD_U_RD  = 15'b000000010000000,
        UPD_U_WR  = 15'b000000100000000,
        UPD_V_RD  = 15'b000001000000000,
        UPD_V_WR  = 15'b000010000000000,
        JOIN_B_RD = 15'b000100000000000,
        JOIN_B_WR = 15'b001000000000000,
        JOIN_A_RD = 15'b010000000000000,
        JOIN_A_WR = 15'b100000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                clr_item_reg, clr_item_next;
    logic [AW-1:0]       u_reg, u_next;
    logic [AW-1:0]       v_reg, v_next;
    logic [AW-1:0]       x_reg, x_next;
    logic [RANK_W-1:0]   xr_reg, xr_next;
    logic [DEG_W-1:0]    xd_reg, xd_next;
    logic                second_reg, second_next;
    logic [AW-1:0]       ru_reg, ru_next;
    logic [RANK_W-1:0]   rank_u_reg, rank_u_next;
    logic [AW-1:0]       a_reg, a_next;
    logic [AW-1:0]       b_reg, b_next;
    logic                inc_reg, inc_next;
    logic [DEG_W-1:0]    du_reg, du_next;
    logic [DEG_W-1:0]    dv_reg, dv_next;
    logic [COUNT_W-1:0]  acc_count_reg, acc_count_next;
    logic [CFG_W-1:0]    city_count_reg, city_count_next;
    logic                done_reg, done_next;
    gea_out_t            result_reg, result_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [WW-1:0]       ram_rdata;

    logic [AW-1:0]       rd_parent;
    logic [RANK_W-1:0]   rd_rank;
    logic [DEG_W-1:0]    rd_deg;
    logic [NW-1:0]       cfg_ext;
    logic [NW-1:0]       n_work;
    logic                take;
    logic                bad_pair;
    logic                quota_full;

    gea_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_CITIES)
    ) u_city_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_parent = ram_rdata[WW-1 -: AW];
    assign rd_rank   = ram_rdata[DEG_W +: RANK_W];
    assign rd_deg    = ram_rdata[DEG_W-1:0];

    assign cfg_ext = NW'(city_count_reg);
    assign n_work  = (cfg_ext < NW'(MAX_CITIES)) ? cfg_ext : NW'(MAX_CITIES);

    assign take = start && !busy;
    assign bad_pair = (NW'(item.first_city) >= n_work) || (NW'(item.second_city) >= n_work)
                      || (item.first_city == item.second_city);
    assign quota_full = (NW'(acc_count_reg) + NW'(1)) >= n_work;

    assign busy      = (state_reg != IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        clr_item_next   = clr_item_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        x_next          = x_reg;
        xr_next         = xr_reg;
        xd_next         = xd_reg;
        second_next     = second_reg;
        ru_next         = ru_reg;
        rank_u_next     = rank_u_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        inc_next        = inc_reg;
        du_next         = du_reg;
        dv_next         = dv_reg;
        acc_count_next  = acc_count_reg;
        city_count_next = city_count_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        ram_we          = 1'b0;
        ram_waddr       = x_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = u_reg;

        if (cfg_valid && cfg_ready)
        begin
            city_count_next = cfg_data;
        end

        case (state_reg)
            IDLE:
            begin
                if (take)
                begin
                    result_next.accepted    = 1'b0;
                    result_next.first_slot  = 1'b0;
                    result_next.second_slot = 1'b0;
                    result_next.edges_taken = acc_count_reg;
                    if (item.mode == MODE_CLEAR)
                    begin
                        clr_next       = '0;
                        clr_item_next  = 1'b1;
                        acc_count_next = '0;
                        state_next     = CLEAR;
                    end
                    else if (bad_pair)
                    begin
                        result_next.verdict = VERDICT_BAD;
                        done_next           = 1'b1;
                    end
                    else if (quota_full)
                    begin
                        result_next.verdict = VERDICT_QUOTA;
                        done_next           = 1'b1;
                    end
                    else
                    begin
                        u_next     = AW'(item.first_city);
                        v_next     = AW'(item.second_city);
                        state_next = RD_U;
                    end
                end
            end
            CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {clr_reg, {RANK_W{1'b0}}, {DEG_W{1'b0}}};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_CITIES - 1))
                begin
                    state_next = IDLE;
                    if (clr_item_reg)
                    begin
                        clr_item_next           = 1'b0;
                        result_next.accepted    = 1'b0;
                        result_next.verdict     = VERDICT_BAD;
                        result_next.first_slot  = 1'b0;
                        result_next.second_slot = 1'b0;
                        result_next.edges_taken = '0;
                        done_next               = 1'b1;
                    end
                end
            end
            RD_U:
            begin
                ram_re     = 1'b1;
                ram_raddr  = u_reg;
                state_next = CHK_U;
            end
            CHK_U:
            begin
                du_next    = rd_deg;
                ram_re     = 1'b1;
                ram_raddr  = v_reg;
                state_next = CHK_V;
            end
            CHK_V:
            begin
                dv_next = rd_deg;
                if ((du_reg >= DEGREE_FULL) || (rd_deg >= DEGREE_FULL))
                begin
                    result_next.accepted    = 1'b0;
                    result_next.verdict     = VERDICT_DEGREE;
                    result_next.first_slot  = 1'b0;
                    result_next.second_slot = 1'b0;
                    result_next.edges_taken = acc_count_reg;
                    done_next               = 1'b1;
                    state_next              = IDLE;
                end
                else
                begin
                    x_next      = u_reg;
                    second_next = 1'b0;
                    ram_re      = 1'b1;
                    ram_raddr   = u_reg;
                    state_next  = FIND_X;
                end
            end
            FIND_X:
            begin
                if (rd_parent == x_reg)
                begin
                    if (!second_reg)
                    begin
                        ru_next     = x_reg;
                        rank_u_next = rd_rank;
                        x_next      = v_reg;
                        second_next = 1'b1;
                        ram_re      = 1'b1;
                        ram_raddr   = v_reg;
                    end
                    else if (x_reg == ru_reg)
                    begin
                        result_next.accepted    = 1'b0;
                        result_next.verdict     = VERDICT_SAME;
                        result_next.first_slot  = 1'b0;
                        result_next.second_slot = 1'b0;
                        result_next.edges_taken = acc_count_reg;
                        done_next               = 1'b1;
                        state_next              = IDLE;
                    end
                    else
                    begin
                        if (rank_u_reg < rd_rank)
                        begin
                            a_next = x_reg;
                            b_next = ru_reg;
                        end
                        else
                        begin
                            a_next = ru_reg;
                            b_next = x_reg;
                        end
                        inc_next   = (rank_u_reg == rd_rank) && (rank_u_reg < RANK_MAX);
                        state_next = UPD_U_RD;
                    end
                end
                else
                begin
                    xr_next    = rd_rank;
                    xd_next    = rd_deg;
                    ram_re     = 1'b1;
                    ram_raddr  = rd_parent;
                    state_next = FIND_P;
                end
            end
            FIND_P:
            begin
                ram_we     = 1'b1;
                ram_waddr  = x_reg;
                ram_wdata  = {rd_parent, xr_reg, xd_reg};
                x_next     = rd_parent;
                ram_re     = 1'b1;
                ram_raddr  = rd_parent;
                state_next = FIND_X;
            end
            UPD_U_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = u_reg;
                state_next = UPD_U_WR;
            end
            UPD_U_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = u_reg;
                ram_wdata  = {rd_parent, rd_rank, rd_deg + 2'd1};
                state_next = UPD_V_RD;
            end
            UPD_V_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = v_reg;
                state_next = UPD_V_WR;
            end
            UPD_V_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = v_reg;
                ram_wdata  = {rd_parent, rd_rank, rd_deg + 2'd1};
                state_next = JOIN_B_RD;
            end
            JOIN_B_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = b_reg;
                state_next = JOIN_B_WR;
            end
            JOIN_B_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = b_reg;
                ram_wdata  = {a_reg, rd_rank, rd_deg};
                state_next = JOIN_A_RD;
            end
            JOIN_A_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = a_reg;
                state_next = JOIN_A_WR;
            end
            JOIN_A_WR:
            begin
                ram_we                  = 1'b1;
                ram_waddr               = a_reg;
                ram_wdata               = {rd_parent, rd_rank + RANK_W'(inc_reg), rd_deg};
                acc_count_next          = acc_count_reg + 1'b1;
                result_next.accepted    = 1'b1;
                result_next.verdict     = VERDICT_ACCEPT;
                result_next.first_slot  = du_reg[0];
                result_next.second_slot = dv_reg[0];
                result_next.edges_taken = acc_count_reg + 1'b1;
                done_next               = 1'b1;
                state_next              = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            clr_reg        <= '0;
            clr_item_reg   <= 1'b0;
            second_reg     <= 1'b0;
            acc_count_reg  <= '0;
            city_count_reg <= CITY_COUNT_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            clr_item_reg   <= clr_item_next;
            second_reg     <= second_next;
            acc_count_reg  <= acc_count_next;
            city_count_reg <= city_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        x_reg      <= x_next;
        xr_reg     <= xr_next;
        xd_reg     <= xd_next;
        ru_reg     <= ru_next;
        rank_u_reg <= rank_u_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        inc_reg    <= inc_next;
        du_reg     <= du_next;
        dv_reg     <= dv_next;
        result_reg <= result_next;
    end

    a_clear_starts_pass: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == MODE_CLEAR) |=> (busy && state_reg == CLEAR))
        else $error("A clear transaction did not start the clearing pass.");

    a_accept_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.accepted) |->
            (result.edges_taken == COUNT_W'($past(acc_count_reg) + 1'b1)
             && result.verdict == VERDICT_ACCEPT))
        else $error("An accepted edge did not advance the edge count by one.");

    a_no_ram_collision: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("The city RAM was read and written at the same entry in one cycle.");

    a_done_ends_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == IDLE))
        else $error("A result was shown while the sequencer was still busy.");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the greedy edge acceptor: union-find scoreboard with directed and random edges.
`default_nettype none

module tb;
    import gea_pkg::*;

    class tour_scoreboard;
        logic [CITY_W-1:0]  parent_of[MAX_CITIES_DEF];
        logic [RANK_W-1:0]  rank_of[MAX_CITIES_DEF];
        logic [DEG_W-1:0]   degree_of[MAX_CITIES_DEF];
        logic [COUNT_W-1:0] edges_so_far;
        logic [CFG_W-1:0]   city_count;
        gea_out_t           expected_verdicts[$];
        int                 mismatches;

        function new();
            city_count = CITY_COUNT_RST;
            mismatches = 0;
            clear_forest();
        endfunction

        function void clear_forest();
            for (int i = 0; i < MAX_CITIES_DEF; i++)
            begin
                parent_of[i] = CITY_W'(i);
                rank_of[i] = '0;
                degree_of[i] = '0;
            end
            edges_so_far = '0;
        endfunction

        function void set_city_count(int value);
            city_count = CFG_W'(value);
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function logic [CITY_W-1:0] find_root(logic [CITY_W-1:0] x);
            logic [CITY_W-1:0] p;
            for (int steps = 0; steps < MAX_CITIES_DEF; steps++)
            begin
                p = parent_of[x];
                if (p == x)
                    break;
                parent_of[x] = parent_of[p];
                x = parent_of[x];
            end
            return x;
        endfunction

        // Predicts the verdict of one accepted transaction and updates the forest.
        function void predict_verdict(gea_in_t it);
            gea_out_t          res;
            int                n;
            logic [CITY_W-1:0] u;
            logic [CITY_W-1:0] v;
            logic [CITY_W-1:0] ru;
            logic [CITY_W-1:0] rv;
            logic [CITY_W-1:0] swap;
            res = '0;
            u = it.first_city;
            v = it.second_city;
            n = (city_count < MAX_CITIES_DEF) ? int'(city_count) : MAX_CITIES_DEF;
            if (it.mode == MODE_CLEAR)
            begin
                clear_forest();
                res.verdict = VERDICT_BAD;
            end
            else if (int'(u) >= n || int'(v) >= n || u == v)
                res.verdict = VERDICT_BAD;
            else if (int'(edges_so_far) + 1 >= n)
                res.verdict = VERDICT_QUOTA;
            else if (degree_of[u] >= DEGREE_FULL || degree_of[v] >= DEGREE_FULL)
                res.verdict = VERDICT_DEGREE;
            else
            begin
                ru = find_root(u);
                rv = find_root(v);
                if (ru == rv)
                    res.verdict = VERDICT_SAME;
                else
                begin
                    res.first_slot = degree_of[u][0];
                    res.second_slot = degree_of[v][0];
                    degree_of[u] = degree_of[u] + 1'b1;
                    degree_of[v] = degree_of[v] + 1'b1;
                    if (rank_of[ru] < rank_of[rv])
                    begin
                        swap = ru;
                        ru = rv;
                        rv = swap;
                    end
                    parent_of[rv] = ru;
                    if (rank_of[ru] == rank_of[rv] && rank_of[ru] < RANK_MAX)
                        rank_of[ru] = rank_of[ru] + 1'b1;
                    edges_so_far = edges_so_far + 1'b1;
                    res.accepted = 1'b1;
                    res.verdict = VERDICT_ACCEPT;
                end
            end
            res.edges_taken = edges_so_far;
            expected_verdicts.insert(expected_verdicts.size(), res);
        endfunction

        function void check_result(gea_out_t got);
            gea_out_t want;
            logic     bad;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: acc=%0d verdict=%0d slots=%0d/%0d taken=%0d",
                             got.accepted, got.verdict, got.first_slot, got.second_slot,
                             got.edges_taken);
                return;
            end
            want = expected_verdicts.pop_front();
            bad = (got.accepted !== want.accepted) || (got.verdict !== want.verdict) ||
                  (got.first_slot !== want.first_slot) ||
                  (got.second_slot !== want.second_slot) ||
                  (got.edges_taken !== want.edges_taken);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("Mismatch: expected acc=%0d verdict=%0d slots=%0d/%0d taken=%0d,",
                           want.accepted, want.verdict, want.first_slot, want.second_slot,
                           want.edges_taken);
                    $display(" got acc=%0d verdict=%0d slots=%0d/%0d taken=%0d",
                             got.accepted, got.verdict, got.first_slot, got.second_slot,
                             got.edges_taken);
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    gea_in_t          item = '0;
    logic             done;
    gea_out_t         result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    tour_scoreboard sb = new();
    int             items_sent = 0;

    greedy_edge_acceptor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    task automatic offer(input logic mode, input int a, input int b);
        gea_in_t it;
        it.mode = mode;
        it.first_city = CITY_W'(a);
        it.second_city = CITY_W'(b);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        sb.predict_verdict(it);
        items_sent++;
        if (!(items_sent >= 400 && items_sent < 550) && $urandom_range(99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_city_count(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_city_count(value);
    endtask

    task automatic run_instance();
        int n;
        int roll;
        int edge_total;
        int base;
        int a;
        int b;
        roll = $urandom_range(99);
        if (roll < 70)
            n = $urandom_range(3, 40);
        else if (roll < 90)
            n = $urandom_range(41, 200);
        else
            n = $urandom_range(1000, 1024);
        write_city_count(n);
        offer(MODE_CLEAR, $urandom_range(1023), $urandom_range(1023));
        edge_total = (n <= 40) ? $urandom_range(n, 3 * n) : $urandom_range(40, 110);
        base = (n > 24) ? $urandom_range(0, n - 24) : 0;
        for (int k = 0; k < edge_total; k++)
        begin
            if (k == edge_total / 2 && $urandom_range(99) < 15)
            begin
                n = $urandom_range(3, 1024);
                write_city_count(n);
                base = (n > 24) ? $urandom_range(0, n - 24) : 0;
            end
            roll = $urandom_range(99);
            if (n > 24 && $urandom_range(99) < 70)
            begin
                a = base + $urandom_range(23);
                b = base + $urandom_range(23);
            end
            else
            begin
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
            end
            if (roll < 6)
                offer(MODE_EDGE, a, a);
            else if (roll < 12)
                offer(MODE_EDGE, $urandom_range(1023), b);
            else if (roll < 14)
                offer(MODE_CLEAR, $urandom_range(1023), $urandom_range(1023));
            else
                offer(MODE_EDGE, a, b);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(MODE_EDGE, 0, 1);
        offer(MODE_EDGE, 1, 2);
        offer(MODE_EDGE, 0, 2);
        offer(MODE_EDGE, 1, 3);
        offer(MODE_EDGE, 1023, 1022);
        offer(MODE_EDGE, 5, 5);
        offer(MODE_EDGE, 0, 1023);
        offer(MODE_EDGE, 1023, 0);
        offer(MODE_CLEAR, 1023, 0);
        offer(MODE_EDGE, 1023, 0);

        write_city_count(3);
        offer(MODE_EDGE, 0, 3);
        offer(MODE_EDGE, 3, 0);
        offer(MODE_EDGE, 0, 1);
        offer(MODE_EDGE, 1, 2);
        offer(MODE_EDGE, 0, 1);
        offer(MODE_CLEAR, 0, 1023);
        offer(MODE_EDGE, 2, 1);

        write_city_count(1024);
        offer(MODE_EDGE, 2, 0);
        offer(MODE_EDGE, 0, 1);
        write_city_count(1023);
        offer(MODE_EDGE, 1023, 5);
        offer(MODE_EDGE, 1022, 5);

        while (items_sent < 830)
            run_instance();

        drain();
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
src/gea_pkg.sv
src/gea_ram.sv
src/greedy_edge_acceptor.sv
tb/sv/tb.sv
